/* design/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/bwep_pkg.sv */
package bwep_pkg;

   localparam int CSR_ADDR_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_SSID_LIMIT      = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATES_LIMIT     = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHALLENGE_LIMIT = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIM_LIMIT       = 8'd3;

   localparam logic [7:0] RST_SSID_LIMIT      = 8'd32;
   localparam logic [7:0] RST_RATES_LIMIT     = 8'd8;
   localparam logic [7:0] RST_CHALLENGE_LIMIT = 8'd253;
   localparam logic [7:0] RST_TIM_LIMIT       = 8'd251;

   localparam logic [7:0] ID_SSID      = 8'd0;
   localparam logic [7:0] ID_RATES     = 8'd1;
   localparam logic [7:0] ID_DS        = 8'd3;
   localparam logic [7:0] ID_CF        = 8'd4;
   localparam logic [7:0] ID_TIM       = 8'd5;
   localparam logic [7:0] ID_CHALLENGE = 8'd16;
   localparam logic [7:0] ID_HTCAP     = 8'd45;

   localparam logic [7:0] DS_BODY_BYTES = 8'd2;
   localparam logic [7:0] CF_BODY_BYTES = 8'd7;
   localparam logic [7:0] TIM_FIXED     = 8'd3;
   localparam logic [6:0] RATE_MASK     = 7'h7f;

   localparam logic [3:0] HDR_CAP_LO = 4'd10;
   localparam logic [3:0] HDR_LAST   = 4'd11;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_ID     = 5'b00010,
      PH_LEN    = 5'b00100,
      PH_BODY   = 5'b01000,
      PH_HALT   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] ssid_limit;
      logic [7:0] rates_limit;
      logic [7:0] challenge_limit;
      logic [7:0] tim_bitmap_limit;
   } limits_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       is_beacon;
      logic       crc_error;
   } req_type;

   typedef struct packed {
      logic       parse_ok;
      logic       header_complete;
      logic       ssid_seen;
      logic [7:0] ssid_length;
      logic       ds_seen;
      logic [7:0] channel;
      logic       rates_seen;
      logic [6:0] top_rate;
      logic       privacy;
      logic       ess_mode;
      logic       ht_enabled;
      logic       tim_seen;
   } rsp_type;

   typedef struct packed {
      logic ssid;
      logic ds;
      logic rates;
      logic tim;
      logic ht;
   } flags_type;

endpackage

/* design/bwep_if.sv */
interface bwep_req_if;
   import bwep_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       is_beacon;
   logic       crc_error;
   modport source (output valid, data_byte, last_byte, is_beacon, crc_error, input ready);
   modport sink   (input valid, data_byte, last_byte, is_beacon, crc_error, output ready);
endinterface

interface bwep_rsp_if;
   import bwep_pkg::*;
   logic       valid;
   logic       ready;
   logic       parse_ok;
   logic       header_complete;
   logic       ssid_seen;
   logic [7:0] ssid_length;
   logic       ds_seen;
   logic [7:0] channel;
   logic       rates_seen;
   logic [6:0] top_rate;
   logic       privacy;
   logic       ess_mode;
   logic       ht_enabled;
   logic       tim_seen;
   modport source (output valid, parse_ok, header_complete, ssid_seen, ssid_length,
                   ds_seen, channel, rates_seen, top_rate, privacy, ess_mode,
                   ht_enabled, tim_seen, input ready);
   modport sink   (input valid, parse_ok, header_complete, ssid_seen, ssid_length,
                   ds_seen, channel, rates_seen, top_rate, privacy, ess_mode,
                   ht_enabled, tim_seen, output ready);
endinterface

interface bwep_csr_if;
   import bwep_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [7:0]            wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

/* design/bwep_csr.sv */
module bwep_csr (
   input  logic                clock,
   input  logic                reset,
   bwep_csr_if.sink            csr_chan,
   output bwep_pkg::limits_type limits
);
   import bwep_pkg::*;

   limits_type limits_ff, limits_in;

   assign csr_chan.ready = 1'b1;
   assign limits         = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_SSID_LIMIT:      limits_in.ssid_limit       = csr_chan.wdata;
            CSR_RATES_LIMIT:     limits_in.rates_limit      = csr_chan.wdata;
            CSR_CHALLENGE_LIMIT: limits_in.challenge_limit  = csr_chan.wdata;
            CSR_TIM_LIMIT:       limits_in.tim_bitmap_limit = csr_chan.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.ssid_limit       <= RST_SSID_LIMIT;
         limits_ff.rates_limit      <= RST_RATES_LIMIT;
         limits_ff.challenge_limit  <= RST_CHALLENGE_LIMIT;
         limits_ff.tim_bitmap_limit <= RST_TIM_LIMIT;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

/* design/bwep_parser.sv */
module bwep_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bwep_pkg::req_type    item,
   input  bwep_pkg::limits_type limits,
   output bwep_pkg::rsp_type    result
);
   import bwep_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] hdr_cnt_ff, hdr_cnt_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] size_ff, size_in;
   logic [7:0] left_ff, left_in;
   logic [1:0] cap_ff, cap_in;      // {privacy, ess}
   flags_type  flags_ff, flags_in;
   logic [7:0] chan_ff, chan_in;
   logic [6:0] pend_ff, pend_in;
   logic [6:0] rate_ff, rate_in;
   logic [7:0] ssid_ff, ssid_in;
   logic       err_ff, err_in;

   logic       done;
   logic       bad;
   logic [7:0] dsize;
   logic [7:0] left_new;
   logic       hdr_ok;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      kind_in    = kind_ff;
      size_in    = size_ff;
      left_in    = left_ff;
      cap_in     = cap_ff;
      flags_in   = flags_ff;
      chan_in    = chan_ff;
      pend_in    = pend_ff;
      rate_in    = rate_ff;
      ssid_in    = ssid_ff;
      err_in     = err_ff;
      done       = 1'b0;
      bad        = 1'b0;
      dsize      = size_ff;
      left_new   = item.data_byte;

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_cnt_ff == HDR_CAP_LO) begin
               cap_in = {item.data_byte[4], item.data_byte[0]};
            end
            hdr_cnt_in = hdr_cnt_ff + 4'd1;
            if (hdr_cnt_ff == HDR_LAST) begin
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            kind_in = item.data_byte;
            size_in = 8'd0;
            priority if (item.data_byte == ID_DS) begin
               left_in  = DS_BODY_BYTES;
               phase_in = PH_BODY;
            end else if (item.data_byte == ID_CF) begin
               left_in  = CF_BODY_BYTES;
               phase_in = PH_BODY;
            end else begin
               if (item.data_byte == ID_HTCAP && item.is_beacon && !item.crc_error) begin
                  flags_in.ht = 1'b1;
               end
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            size_in = item.data_byte;
            dsize   = item.data_byte;
            unique case (kind_ff)
               ID_SSID:      bad = item.data_byte > limits.ssid_limit;
               ID_RATES:     bad = item.data_byte > limits.rates_limit;
               ID_CHALLENGE: bad = item.data_byte > limits.challenge_limit;
               ID_TIM:       bad = (item.data_byte > TIM_FIXED) &&
                                   ((item.data_byte - TIM_FIXED) > limits.tim_bitmap_limit);
               default:      bad = 1'b0;
            endcase
            if (kind_ff == ID_TIM && item.data_byte <= TIM_FIXED) begin
               left_new = TIM_FIXED;
            end
            priority if (bad) begin
               err_in   = 1'b1;
               phase_in = PH_HALT;
            end else begin
               left_in = left_new;
               if (left_new == 8'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (kind_ff == ID_RATES) begin
               pend_in = item.data_byte[6:0] & RATE_MASK;
            end
            if (kind_ff == ID_DS && left_ff == 8'd1 && !flags_ff.ds) begin
               chan_in = item.data_byte;
            end
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               done = 1'b1;
            end
         end
         PH_HALT: ;
         default: ;
      endcase

      // element finished: record first of each kind
      if (done) begin
         phase_in = PH_ID;
         unique case (kind_ff)
            ID_SSID: begin
               if (!flags_ff.ssid) begin
                  ssid_in       = dsize;
                  flags_in.ssid = 1'b1;
               end
            end
            ID_RATES: begin
               if (!flags_ff.rates && dsize != 8'd0) begin
                  rate_in        = pend_in;
                  flags_in.rates = 1'b1;
               end
            end
            ID_DS:   flags_in.ds = 1'b1;
            ID_TIM:  if (dsize > TIM_FIXED) flags_in.tim = 1'b1;
            default: ;
         endcase
      end
   end

   assign hdr_ok = phase_in != PH_HEADER;

   always_comb begin
      result.parse_ok        = !err_in && phase_in == PH_ID;
      result.header_complete = hdr_ok;
      result.ssid_seen       = flags_in.ssid;
      result.ssid_length     = flags_in.ssid ? ssid_in : 8'd0;
      result.ds_seen         = flags_in.ds;
      result.channel         = flags_in.ds ? chan_in : 8'd0;
      result.rates_seen      = flags_in.rates;
      result.top_rate        = flags_in.rates ? (rate_in & RATE_MASK) : 7'd0;
      result.privacy         = hdr_ok && cap_in[1];
      result.ess_mode        = hdr_ok && cap_in[0];
      result.ht_enabled      = flags_in.ht;
      result.tim_seen        = flags_in.tim;
   end

   // last byte of a frame clears all per-frame state
   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= 4'd0;
         kind_ff    <= 8'd0;
         size_ff    <= 8'd0;
         left_ff    <= 8'd0;
         cap_ff     <= 2'd0;
         flags_ff   <= '0;
         chan_ff    <= 8'd0;
         pend_ff    <= 7'd0;
         rate_ff    <= 7'd0;
         ssid_ff    <= 8'd0;
         err_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         kind_ff    <= kind_in;
         size_ff    <= size_in;
         left_ff    <= left_in;
         cap_ff     <= cap_in;
         flags_ff   <= flags_in;
         chan_ff    <= chan_in;
         pend_ff    <= pend_in;
         rate_ff    <= rate_in;
         ssid_ff    <= ssid_in;
         err_ff     <= err_in;
      end
   end

endmodule

/* design/wifi_beacon_element_parser.sv */
// Beacon / probe-response body parser.
// req_chan carries the frame body one byte per transaction, with last_byte
// on the final byte and the is_beacon / crc_error qualifiers alongside.
// rsp_chan gives one summary transaction per frame, after its last byte.
// csr_chan writes the four length limits (index 0..3); ready is always high,
// and writes are expected only while no frame is in flight.
// Throughput: one byte per cycle, except while a last byte waits on a pending
// summary; each byte sits in an input register, and the element-walk logic
// updates the parse state from it and, for a last byte, fills the result register.
// The summary register loads as the last byte leaves the input register.
// Reset: limits return to defaults, parse state returns to the header phase,
// both pipeline registers empty.
// Stall: while a summary waits on rsp_chan.ready, bytes of the next frame
// keep flowing; only a further last byte holds in the input register, and
// req_chan.ready drops once that register is occupied.
`include "assert_macros.svh"

module wifi_beacon_element_parser (
   input  logic        clock,
   input  logic        reset,
   bwep_req_if.sink    req_chan,
   bwep_rsp_if.source  rsp_chan,
   bwep_csr_if.sink    csr_chan
);
   import bwep_pkg::*;

   logic       in_vld_ff, in_vld_in;
   req_type    in_item_ff;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_data_ff;
   rsp_type    result;
   limits_type limits;
   logic       advance;
   logic       req_take;

   bwep_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .limits   (limits)
   );

   bwep_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .limits  (limits),
      .result  (result)
   );

   assign advance = in_vld_ff && (!in_item_ff.last_byte || !out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance && in_item_ff.last_byte) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte <= req_chan.data_byte;
         in_item_ff.last_byte <= req_chan.last_byte;
         in_item_ff.is_beacon <= req_chan.is_beacon;
         in_item_ff.crc_error <= req_chan.crc_error;
      end
      if (advance && in_item_ff.last_byte) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.parse_ok        = out_data_ff.parse_ok;
   assign rsp_chan.header_complete = out_data_ff.header_complete;
   assign rsp_chan.ssid_seen       = out_data_ff.ssid_seen;
   assign rsp_chan.ssid_length     = out_data_ff.ssid_length;
   assign rsp_chan.ds_seen         = out_data_ff.ds_seen;
   assign rsp_chan.channel         = out_data_ff.channel;
   assign rsp_chan.rates_seen      = out_data_ff.rates_seen;
   assign rsp_chan.top_rate        = out_data_ff.top_rate;
   assign rsp_chan.privacy         = out_data_ff.privacy;
   assign rsp_chan.ess_mode        = out_data_ff.ess_mode;
   assign rsp_chan.ht_enabled      = out_data_ff.ht_enabled;
   assign rsp_chan.tim_seen        = out_data_ff.tim_seen;

   `ASSERT_IMPLIES(a_no_in_overwrite, clock, reset, req_take && in_vld_ff, advance)
   `ASSERT_IMPLIES(a_no_out_overwrite, clock, reset, out_vld_ff && !rsp_chan.ready,
      !(advance && in_item_ff.last_byte))
   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, advance && in_item_ff.last_byte, out_vld_ff)

endmodule

/* verif/wifi_beacon_element_parser_tb.sv */
`timescale 1ns / 100ps

module wifi_beacon_element_parser_tb;
   import bwep_pkg::*;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   bwep_req_if req_bus ();
   bwep_rsp_if rsp_bus ();
   bwep_csr_if csr_bus ();

   wifi_beacon_element_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // parser state as the block should hold it
   limits_type  lim;
   logic [3:0]  hdr_cnt;
   phase_type   walk_ph;
   logic [7:0]  el_id;
   logic [7:0]  el_len;
   logic [8:0]  el_left;
   logic [15:0] cap_word;
   logic        got_ssid, got_ds, got_rates, got_tim, got_ht;
   logic [7:0]  chan_hold;
   logic [7:0]  ssid_len_hold;
   logic [6:0]  rate_pend;
   logic [6:0]  rate_hold;
   logic        err_seen;

   rsp_type     summary_q[$];
   dir_row_type dir_tab[$];
   int          bad_summaries;
   int          items_sent;
   int          send_idle_pct;
   int          recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[wifi_beacon_element_parser] ERROR");
      $finish;
   end

   function automatic void clear_frame();
      hdr_cnt       = '0;
      walk_ph       = PH_HEADER;
      el_id         = '0;
      el_len        = '0;
      el_left       = '0;
      cap_word      = '0;
      got_ssid      = 1'b0;
      got_ds        = 1'b0;
      got_rates     = 1'b0;
      got_tim       = 1'b0;
      got_ht        = 1'b0;
      chan_hold     = '0;
      ssid_len_hold = '0;
      rate_pend     = '0;
      rate_hold     = '0;
      err_seen      = 1'b0;
   endfunction

   function automatic void close_element();
      case (el_id)
         ID_SSID: begin
            if (!got_ssid) begin
               ssid_len_hold = el_len;
               got_ssid      = 1'b1;
            end
         end
         ID_RATES: begin
            if (!got_rates && el_len != 0) begin
               rate_hold = rate_pend;
               got_rates = 1'b1;
            end
         end
         ID_DS: got_ds = 1'b1;
         ID_TIM: begin
            if (el_len > TIM_FIXED) got_tim = 1'b1;
         end
         default: ;
      endcase
      walk_ph = PH_ID;
   endfunction

   // advances the parser by one byte; returns 1 with the frame summary on the last byte
   function automatic bit walk_byte(input req_type it, output rsp_type sum);
      logic [7:0] b;
      logic       too_long;
      b        = it.data_byte;
      too_long = 1'b0;
      sum      = '0;
      case (walk_ph)
         PH_HEADER: begin
            if (hdr_cnt == HDR_CAP_LO) cap_word = {8'h00, b};
            else if (hdr_cnt == HDR_LAST) cap_word[15:8] = b;
            if (hdr_cnt == HDR_LAST) walk_ph = PH_ID;
            hdr_cnt = hdr_cnt + 4'd1;
         end
         PH_ID: begin
            el_id  = b;
            el_len = '0;
            if (b == ID_DS) begin
               el_left = {1'b0, DS_BODY_BYTES};
               walk_ph = PH_BODY;
            end else if (b == ID_CF) begin
               el_left = {1'b0, CF_BODY_BYTES};
               walk_ph = PH_BODY;
            end else begin
               if (b == ID_HTCAP && it.is_beacon && !it.crc_error) got_ht = 1'b1;
               walk_ph = PH_LEN;
            end
         end
         PH_LEN: begin
            el_len = b;
            case (el_id)
               ID_SSID:      too_long = b > lim.ssid_limit;
               ID_RATES:     too_long = b > lim.rates_limit;
               ID_CHALLENGE: too_long = b > lim.challenge_limit;
               ID_TIM:       too_long = b > TIM_FIXED &&
                                        8'(b - TIM_FIXED) > lim.tim_bitmap_limit;
               default: ;
            endcase
            if (too_long) begin
               err_seen = 1'b1;
               walk_ph  = PH_HALT;
            end else begin
               if (el_id == ID_TIM && b <= TIM_FIXED) el_left = {1'b0, TIM_FIXED};
               else el_left = {1'b0, b};
               if (el_left == 0) close_element();
               else walk_ph = PH_BODY;
            end
         end
         PH_BODY: begin
            if (el_id == ID_RATES) rate_pend = b[6:0] & RATE_MASK;
            if (el_id == ID_DS && el_left == 1 && !got_ds) chan_hold = b;
            el_left = el_left - 9'd1;
            if (el_left == 0) close_element();
         end
         default: ;
      endcase
      if (!it.last_byte) return 1'b0;
      sum.parse_ok        = !err_seen && walk_ph == PH_ID;
      sum.header_complete = walk_ph != PH_HEADER;
      sum.ssid_seen       = got_ssid;
      sum.ssid_length     = got_ssid ? ssid_len_hold : 8'h00;
      sum.ds_seen         = got_ds;
      sum.channel         = got_ds ? chan_hold : 8'h00;
      sum.rates_seen      = got_rates;
      sum.top_rate        = got_rates ? (rate_hold & RATE_MASK) : 7'h00;
      sum.privacy         = sum.header_complete && cap_word[4];
      sum.ess_mode        = sum.header_complete && cap_word[0];
      sum.ht_enabled      = got_ht;
      sum.tim_seen        = got_tim;
      clear_frame();
      return 1'b1;
   endfunction

   function automatic void add_dir(input logic [7:0] d, input logic last, input logic beacon,
                                   input logic crc, input bit typed = 1'b0,
                                   input rsp_type want = '0);
      dir_row_type row;
      row.item  = '{d, last, beacon, crc};
      row.typed = typed;
      row.want  = want;
      dir_tab.push_back(row);
   endfunction

   function automatic void load_directed();
      rsp_type w;
      // one-byte frame: short header, nothing recorded
      add_dir(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, '0);
      // full header with privacy and ESS, HT element in a clean beacon, DS channel last
      for (int k = 0; k < 10; k++) add_dir(k[0] ? 8'h00 : 8'hff, 1'b0, 1'b0, 1'b1);
      add_dir(8'h11, 1'b0, 1'b0, 1'b1);
      add_dir(8'hff, 1'b0, 1'b0, 1'b1);
      add_dir(ID_HTCAP, 1'b0, 1'b1, 1'b0);
      add_dir(8'h00, 1'b0, 1'b0, 1'b1);
      add_dir(ID_DS, 1'b0, 1'b1, 1'b0);
      add_dir(8'h7f, 1'b0, 1'b1, 1'b0);
      w                 = '0;
      w.parse_ok        = 1'b1;
      w.header_complete = 1'b1;
      w.ds_seen         = 1'b1;
      w.channel         = 8'hff;
      w.privacy         = 1'b1;
      w.ess_mode        = 1'b1;
      w.ht_enabled      = 1'b1;
      add_dir(8'hff, 1'b1, 1'b1, 1'b0, 1'b1, w);
      // SSID length over the limit ends the parse
      for (int k = 0; k < 10; k++) add_dir(k[0] ? 8'h00 : 8'hff, 1'b0, 1'b1, 1'b0);
      add_dir(8'hee, 1'b0, 1'b1, 1'b0);
      add_dir(8'h00, 1'b0, 1'b1, 1'b0);
      add_dir(ID_SSID, 1'b0, 1'b0, 1'b0);
      w                 = '0;
      w.header_complete = 1'b1;
      add_dir(8'hff, 1'b1, 1'b0, 1'b0, 1'b1, w);
   endfunction

   function automatic logic [7:0] pick_len(input logic [7:0] cap);
      int r;
      r = $urandom_range(0, 39);
      if (r < 32 || (r < 38 && cap == 8'hff)) return 8'($urandom_range(0, (cap < 6) ? cap : 6));
      if (r < 35) return cap;
      if (r < 38) return 8'($urandom_range(int'(cap) + 1, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_item(input req_type it, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type sum;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= it.data_byte;
      req_bus.last_byte <= it.last_byte;
      req_bus.is_beacon <= it.is_beacon;
      req_bus.crc_error <= it.crc_error;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (walk_byte(it, sum)) summary_q.push_back(typed ? want : sum);
   endtask

   task automatic send_frame();
      logic [7:0] kinds[8] = '{ID_SSID, ID_RATES, ID_DS, ID_CF, ID_TIM, ID_CHALLENGE,
                               ID_HTCAP, 8'h00};
      logic [7:0] body[$];
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] tim_cap;
      logic       beacon;
      logic       crc;
      int         kind;
      int         cut;
      req_type    it;
      beacon  = $urandom_range(0, 3) != 0;
      crc     = $urandom_range(0, 4) == 0;
      tim_cap = (lim.tim_bitmap_limit > 8'd252) ? 8'hff : lim.tim_bitmap_limit + TIM_FIXED;
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
      end else begin
         repeat (12) body.push_back(8'($urandom));
         repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 7);
            id   = (kind == 7) ? 8'($urandom) : kinds[kind];
            body.push_back(id);
            case (id)
               ID_DS: repeat (DS_BODY_BYTES) body.push_back(8'($urandom));
               ID_CF: repeat (CF_BODY_BYTES) body.push_back(8'($urandom));
               default: begin
                  case (id)
                     ID_SSID:      len = pick_len(lim.ssid_limit);
                     ID_RATES:     len = pick_len(lim.rates_limit);
                     ID_CHALLENGE: len = pick_len(lim.challenge_limit);
                     ID_TIM:       len = pick_len(tim_cap);
                     default: len = ($urandom_range(0, 19) == 0) ?
                                    8'($urandom) : 8'($urandom_range(0, 4));
                  endcase
                  body.push_back(len);
                  if (id == ID_TIM && len <= TIM_FIXED) len = TIM_FIXED;
                  repeat (len) body.push_back(8'($urandom));
               end
            endcase
         end
         // broken endings: cut inside an element or leave a dangling id
         case ($urandom_range(0, 9))
            0: begin
               cut = $urandom_range(1, 3);
               while (cut > 0 && body.size() > 1) begin
                  void'(body.pop_back());
                  cut--;
               end
            end
            1: body.push_back(8'($urandom));
            default: ;
         endcase
      end
      foreach (body[k]) begin
         if ($urandom_range(0, 15) == 0) begin
            beacon = 1'($urandom);
            crc    = 1'($urandom);
         end
         it.data_byte = body[k];
         it.last_byte = (k == body.size() - 1);
         it.is_beacon = beacon;
         it.crc_error = crc;
         push_item(it);
      end
   endtask

   task automatic write_limits(input limits_type v);
      logic [7:0]            vals[4];
      logic [CSR_ADDR_W-1:0] idx[4];
      vals = '{v.ssid_limit, v.rates_limit, v.challenge_limit, v.tim_bitmap_limit};
      idx  = '{CSR_SSID_LIMIT, CSR_RATES_LIMIT, CSR_CHALLENGE_LIMIT, CSR_TIM_LIMIT};
      for (int k = 0; k < 4; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.addr  <= idx[k];
         csr_bus.wdata <= vals[k];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      lim = v;
   endtask

   // wait out every summary, then the pipeline of the bytes that give none
   task automatic drain();
      while (summary_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (recv_idle_pct == 0) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= $urandom_range(0, 99) >= recv_idle_pct;
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.parse_ok        = rsp_bus.parse_ok;
         got.header_complete = rsp_bus.header_complete;
         got.ssid_seen       = rsp_bus.ssid_seen;
         got.ssid_length     = rsp_bus.ssid_length;
         got.ds_seen         = rsp_bus.ds_seen;
         got.channel         = rsp_bus.channel;
         got.rates_seen      = rsp_bus.rates_seen;
         got.top_rate        = rsp_bus.top_rate;
         got.privacy         = rsp_bus.privacy;
         got.ess_mode        = rsp_bus.ess_mode;
         got.ht_enabled      = rsp_bus.ht_enabled;
         got.tim_seen        = rsp_bus.tim_seen;
         if (summary_q.size() == 0) begin
            bad_summaries++;
            if (bad_summaries <= 10) $display("unexpected summary transaction %p", got);
         end else begin
            want = summary_q.pop_front();
            if (got.parse_ok !== want.parse_ok ||
                got.header_complete !== want.header_complete ||
                got.ssid_seen !== want.ssid_seen ||
                got.ssid_length !== want.ssid_length ||
                got.ds_seen !== want.ds_seen ||
                got.channel !== want.channel ||
                got.rates_seen !== want.rates_seen ||
                got.top_rate !== want.top_rate ||
                got.privacy !== want.privacy ||
                got.ess_mode !== want.ess_mode ||
                got.ht_enabled !== want.ht_enabled ||
                got.tim_seen !== want.tim_seen) begin
               bad_summaries++;
               if (bad_summaries <= 10)
                  $display("summary mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      limits_type plan[6];
      int         goal;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      req_bus.is_beacon = 1'b0;
      req_bus.crc_error = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.addr      = '0;
      csr_bus.wdata     = '0;
      send_idle_pct     = 38;
      recv_idle_pct     = 46;
      bad_summaries     = 0;
      items_sent        = 0;
      lim = '{RST_SSID_LIMIT, RST_RATES_LIMIT, RST_CHALLENGE_LIMIT, RST_TIM_LIMIT};
      clear_frame();
      load_directed();
      plan[0] = lim;
      plan[1] = '{8'h00, 8'h00, 8'h00, 8'h00};
      plan[2] = '{8'hff, 8'hff, 8'hff, 8'hff};
      plan[3] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      plan[4] = '{8'd4, 8'd2, 8'd3, 8'd1};
      plan[5] = '{8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                  8'($urandom), 8'($urandom_range(0, 6))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[k]) push_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            req_bus.valid <= 1'b0;
            drain();
            write_limits(plan[ph]);
         end
         if (ph < 2) begin
            send_idle_pct = 38;
            recv_idle_pct = 46;
         end else if (ph < 4) begin
            send_idle_pct = 46;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         goal = items_sent + 333;
         while (items_sent < goal) send_frame();
      end
      req_bus.valid <= 1'b0;
      drain();
      if (bad_summaries == 0 && summary_q.size() == 0) begin
         $display("[wifi_beacon_element_parser] OK");
      end else begin
         $display("[wifi_beacon_element_parser] ERROR");
      end
      $finish;
   end

endmodule
